// ===== sv/bspq_pkg.sv =====
package bspq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int ID_W   = 16;
   localparam int PRIO_W = 8;
   localparam int OCC_W  = 7;
   localparam int STAT_W = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } cell_cmd_type;

endpackage

// ===== sv/bounded_sorted_priority_queue.sv =====
// Bounded priority queue of (id, priority) entries held as a sorted row of cells.
// Request channel: req_op, req_entry_id and req_entry_priority are taken at a
// rising edge where start is high and busy is low. busy stays low, so a request
// may be issued on every cycle.
// Result channel: exactly one result per request, shown for one cycle with
// rsp_strobe high, on the cycle right after the request edge (throughput one
// request per cycle). The receiver cannot stall the results.
// A push places the entry in the row at once: every cell compares its own
// priority with the new one and either holds, takes the new entry or takes its
// upper neighbor's entry. A pop shifts the whole row up by one; cell 0 always
// holds the most urgent entry (smallest priority, newest first among equals).
// A push to a full queue is dropped with status 1; a pop of an empty queue
// returns status 2. Every result carries occupancy and an empty flag.
// Reset clears the entry count and the result strobe; cell contents are not
// cleared and are read only where the count says they are held.
module bounded_sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [15:0] req_entry_id,
   input  logic [7:0]  req_entry_priority,
   output logic        rsp_strobe,
   output logic        rsp_pop_valid,
   output logic [15:0] rsp_out_id,
   output logic [7:0]  rsp_out_priority,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_occupancy,
   output logic        rsp_queue_empty
);

   localparam int Depth = bspq_pkg::QUEUE_DEPTH;

   bspq_pkg::count_type    count_ff, count_in;
   bspq_pkg::cell_cmd_type cmd;
   bspq_pkg::entry_type    cell_entry [Depth];
   logic [Depth-1:0]       cell_ins;
   logic [Depth-1:0]       cell_occ;

   logic accept, is_full, is_empty, push_ok, pop_ok;

   logic                              rsp_strobe_ff;
   logic                              rsp_pop_valid_ff, rsp_pop_valid_in;
   logic [bspq_pkg::ID_W-1:0]         rsp_out_id_ff, rsp_out_id_in;
   logic [bspq_pkg::PRIO_W-1:0]       rsp_out_priority_ff, rsp_out_priority_in;
   logic [bspq_pkg::STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [bspq_pkg::OCC_W-1:0]        rsp_occupancy_ff, rsp_occupancy_in;
   logic                              rsp_queue_empty_ff, rsp_queue_empty_in;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == bspq_pkg::count_type'(Depth));
   assign is_empty = (count_ff == '0);
   assign push_ok  = accept && (req_op == bspq_pkg::OP_PUSH) && !is_full;
   assign pop_ok   = accept && (req_op == bspq_pkg::OP_POP) && !is_empty;

   assign cmd.push = push_ok;
   assign cmd.pop  = pop_ok;
   assign cmd.id   = req_entry_id;
   assign cmd.prio = req_entry_priority;

   for (genvar k = 0; k < Depth; k++) begin : g_cell
      bspq_pkg::entry_type prev_e, next_e;
      logic                prev_i;

      assign cell_occ[k] = (count_ff > bspq_pkg::count_type'(k));

      if (k == 0) begin : g_top
         assign prev_e = '0;
         assign prev_i = 1'b0;
      end else begin : g_mid
         assign prev_e = cell_entry[k-1];
         assign prev_i = cell_ins[k-1];
      end

      if (k == Depth - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_inner
         assign next_e = cell_entry[k+1];
      end

      bspq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (cell_occ[k]),
         .prev_ins   (prev_i),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .ins        (cell_ins[k]),
         .entry      (cell_entry[k])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (push_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_pop_valid_in    = pop_ok;
      rsp_out_id_in       = '0;
      rsp_out_priority_in = '0;
      rsp_status_in       = bspq_pkg::ST_OK;
      if (pop_ok) begin
         rsp_out_id_in       = cell_entry[0].id;
         rsp_out_priority_in = cell_entry[0].prio;
      end
      if (req_op == bspq_pkg::OP_PUSH && is_full) begin
         rsp_status_in = bspq_pkg::ST_FULL;
      end else if (req_op == bspq_pkg::OP_POP && is_empty) begin
         rsp_status_in = bspq_pkg::ST_EMPTY;
      end
      rsp_occupancy_in   = bspq_pkg::OCC_W'(count_in);
      rsp_queue_empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   // hold result payload between requests
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_pop_valid_ff    <= rsp_pop_valid_in;
         rsp_out_id_ff       <= rsp_out_id_in;
         rsp_out_priority_ff <= rsp_out_priority_in;
         rsp_status_ff       <= rsp_status_in;
         rsp_occupancy_ff    <= rsp_occupancy_in;
         rsp_queue_empty_ff  <= rsp_queue_empty_in;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_pop_valid    = rsp_pop_valid_ff;
   assign rsp_out_id       = rsp_out_id_ff;
   assign rsp_out_priority = rsp_out_priority_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_occupancy    = rsp_occupancy_ff;
   assign rsp_queue_empty  = rsp_queue_empty_ff;

endmodule

// ===== sv/bspq_cell.sv =====
module bspq_cell (
   input  logic                  clock,
   input  bspq_pkg::cell_cmd_type cmd,
   input  logic                  occupied,
   input  logic                  prev_ins,
   input  bspq_pkg::entry_type   prev_entry,
   input  bspq_pkg::entry_type   next_entry,
   output logic                  ins,
   output bspq_pkg::entry_type   entry
);

   bspq_pkg::entry_type entry_ff;
   bspq_pkg::entry_type entry_in;
   logic                take_new;

   // new entry lands at or above this cell when the slot is free or its entry is no more urgent
   assign ins      = !occupied || (entry_ff.prio >= cmd.prio);
   assign take_new = ins && !prev_ins;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.pop) begin
         entry_in = next_entry;
      end else if (cmd.push) begin
         if (prev_ins) begin
            entry_in = prev_entry;
         end else if (take_new) begin
            entry_in.id   = cmd.id;
            entry_in.prio = cmd.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== sv/bspq_checker.sv =====
module bspq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_op,
   input logic        rsp_strobe,
   input logic        rsp_pop_valid,
   input logic [15:0] rsp_out_id,
   input logic [7:0]  rsp_out_priority,
   input logic [1:0]  rsp_status,
   input logic [6:0]  rsp_occupancy,
   input logic        rsp_queue_empty
);

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("request without result");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without request");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_pop_valid) |->
         (rsp_status == bspq_pkg::ST_OK && $past(req_op) == bspq_pkg::OP_POP))
      else $error("popped entry with bad status");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_pop_valid) |-> (rsp_out_id == '0 && rsp_out_priority == '0))
      else $error("payload not cleared");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_queue_empty) |-> (rsp_occupancy == '0))
      else $error("empty queue with nonzero occupancy");

endmodule

bind bounded_sorted_priority_queue bspq_checker u_bspq_checker (.*);
